@@ design/nsosc_pkg.sv @@
// Package for the MIDI note sine oscillator: command and status codes,
// fixed-point constants, and elaboration-time helpers for the sine and pitch tables.
// No dependencies.
package nsosc_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MIDI = 1'b1;

  localparam logic [7:0] NOTE_ON  = 8'h90;
  localparam logic [7:0] NOTE_OFF = 8'h80;
  localparam logic [6:0] FIRST_NOTE = 7'h24;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // True when the truncated Q30 twelfth power of q stays at or below two.
  function automatic logic pow12_fits(logic [63:0] q);
    logic [63:0] acc;
    logic fits;
    acc = Q30_ONE;
    fits = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (fits) begin
        acc = (acc * q) >> 30;
        if (acc > (Q30_ONE << 1)) begin
          fits = 1'b0;
        end
      end
    end
    return fits;
  endfunction

  // Largest Q30 semitone ratio whose truncated twelfth power does not exceed two.
  function automatic logic [63:0] semitone_ratio();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = Q30_ONE;
    hi = Q30_ONE << 1;
    for (int n = 0; n < 40; n++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (pow12_fits(mid)) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo;
  endfunction

  // Q30 ratio raised to the power s, with each product truncated.
  function automatic logic [63:0] semitone_pow(int s);
    logic [63:0] r;
    logic [63:0] acc;
    r = semitone_ratio();
    acc = Q30_ONE;
    for (int k = 1; k < 12; k++) begin
      if (k <= s) begin
        acc = (acc * r) >> 30;
      end
    end
    return acc;
  endfunction

  // 127 * sin(pi/2 * m / 2^qbits), truncated, from a Taylor series in Q30.
  function automatic logic [6:0] quarter_sine(logic [63:0] m, int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] usum;
    if (m >= (64'd1 << qbits)) begin
      return 7'd127;
    end
    x = (HALF_PI_Q30 * m) >> qbits;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    usum = $unsigned(sum);
    return 7'((usum * 64'd127) >> 30);
  endfunction

endpackage

@@ design/nsosc_sine.sv @@
// Sine lookup for the oscillator: quarter-wave table with mirroring and sign fold,
// producing an offset-binary 8-bit sample. Depends on nsosc_pkg.
module nsosc_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic [SINE_TABLE_BITS-1:0] phase_idx,
  output logic [7:0]                 sample
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QB;

  logic [6:0]    qtab [QUARTER];
  logic [1:0]    quad;
  logic [QB-1:0] m;
  logic [QB-1:0] m_mirror;
  logic [6:0]    mag;

  for (genvar k = 0; k < QUARTER; k++) begin : g_qtab
    localparam logic [6:0] V = nsosc_pkg::quarter_sine(64'(k), QB);
    assign qtab[k] = V;
  end

  assign quad     = phase_idx[SINE_TABLE_BITS-1 -: 2];
  assign m        = phase_idx[QB-1:0];
  assign m_mirror = ~m + QB'(1);

  always_comb begin
    if (quad[0]) begin
      mag = (m == '0) ? 7'd127 : qtab[m_mirror];
    end else begin
      mag = qtab[m];
    end
    sample = quad[1] ? (8'd128 - {1'b0, mag}) : (8'd128 + {1'b0, mag});
  end

endmodule

@@ design/nsosc_note_rom.sv @@
// Equal-tempered phase increment table, one entry per note from the first table note,
// built at elaboration. Depends on nsosc_pkg.
module nsosc_note_rom #(
  parameter int SAMPLE_RATE = 44100,
  parameter int NOTE_COUNT  = 64,
  parameter int PHASE_BITS  = 32
) (
  input  logic [((NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1)-1:0] note_offset,
  output logic [PHASE_BITS-1:0]                                 increment
);

  logic [PHASE_BITS-1:0] rom [NOTE_COUNT];

  // Rounded increment for note FIRST_NOTE + i, frequency 440 * 2^((n - 69) / 12).
  function automatic logic [63:0] note_inc(int i);
    int d;
    int o;
    int s;
    int sh;
    logic [63:0] num;
    logic [63:0] q;
    d = int'(nsosc_pkg::FIRST_NOTE) + i - 69;
    o = (d >= 0) ? d / 12 : -((-d + 11) / 12);
    s = d - 12 * o;
    sh = o + PHASE_BITS - 30;
    num = 64'd440 * nsosc_pkg::semitone_pow(s);
    if (sh >= 0) begin
      q = ((num << sh) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
    end else begin
      q = ((num + (64'(SAMPLE_RATE) << (-sh - 1))) >> (-sh)) / 64'(SAMPLE_RATE);
    end
    return q;
  endfunction

  for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_rom
    localparam logic [63:0] INC = note_inc(i);
    assign rom[i] = INC[PHASE_BITS-1:0];
  end

  always_comb begin
    if (32'(note_offset) < 32'(NOTE_COUNT)) begin
      increment = rom[note_offset];
    end else begin
      increment = '0;
    end
  end

endmodule

@@ design/midi_note_sine_oscillator_core.sv @@
// Top level of the MIDI note sine oscillator: input register, phase accumulator,
// note state and output register. Depends on nsosc_pkg, nsosc_sine and nsosc_note_rom.
//
//  Channel  Ports                          Contents
//  in       in_tvalid/in_tready/in_tdata   tick or MIDI message, tuser selects
//  out      out_tvalid/out_tready/out_tdata one 8-bit sample per tick
//
// An item is registered on acceptance; a new item can be taken every cycle unless a
// tick waits on a stalled output. The phase add and table reads set the cycle time.
// A tick's sample enters the output register as the tick leaves the input register; a
// MIDI message yields nothing. A stalled output holds the sample and stops ticks
// behind it. Reset clears phase and note state and selects the 1 Hz increment.
module midi_note_sine_oscillator_core #(
  parameter int SAMPLE_RATE     = 44100,
  parameter int NOTE_COUNT      = 64,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] status_byte, [14:8] note_number, [15] zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] sample
);

  localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam logic [PHASE_BITS-1:0] ONE_HZ =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_cmd_r;
  logic [7:0]            s1_status_r;
  logic [6:0]            s1_note_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] inc_r, inc_nxt;
  logic [6:0]            playing_note_r, playing_note_nxt;
  logic                  note_active_r, note_active_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_sample_r, out_sample_nxt;

  logic                  in_accept;
  logic                  s1_is_tick;
  logic                  s1_adv;
  logic [6:0]            note_off7;
  logic                  note_in_range;
  logic [PHASE_BITS-1:0] note_inc;
  logic [7:0]            sine_sample;

  nsosc_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .phase_idx(phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .sample   (sine_sample)
  );

  nsosc_note_rom #(
    .SAMPLE_RATE(SAMPLE_RATE),
    .NOTE_COUNT (NOTE_COUNT),
    .PHASE_BITS (PHASE_BITS)
  ) u_note_rom (
    .note_offset(note_off7[IDX_W-1:0]),
    .increment  (note_inc)
  );

  assign s1_is_tick = (s1_cmd_r == nsosc_pkg::CMD_TICK);
  assign s1_adv     = s1_valid_r && (!s1_is_tick || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_accept  = in_tvalid && in_tready;

  assign note_off7     = s1_note_r - nsosc_pkg::FIRST_NOTE;
  assign note_in_range = (s1_note_r >= nsosc_pkg::FIRST_NOTE) &&
                         (32'(note_off7) < 32'(NOTE_COUNT));

  always_comb begin
    s1_valid_nxt     = s1_valid_r;
    phase_nxt        = phase_r;
    inc_nxt          = inc_r;
    playing_note_nxt = playing_note_r;
    note_active_nxt  = note_active_r;
    out_valid_nxt    = out_valid_r;
    out_sample_nxt   = out_sample_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      if (s1_is_tick) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = sine_sample;
        phase_nxt      = phase_r + inc_r;
      end else if (s1_cmd_r == nsosc_pkg::CMD_MIDI && note_in_range) begin
        if (s1_status_r == nsosc_pkg::NOTE_ON) begin
          inc_nxt          = note_inc;
          playing_note_nxt = s1_note_r;
          note_active_nxt  = 1'b1;
        end else if (s1_status_r == nsosc_pkg::NOTE_OFF) begin
          if (note_active_r && playing_note_r == s1_note_r) begin
            inc_nxt         = ONE_HZ;
            note_active_nxt = 1'b0;
          end
        end
      end
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      phase_r        <= '0;
      inc_r          <= ONE_HZ;
      playing_note_r <= '0;
      note_active_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      phase_r        <= phase_nxt;
      inc_r          <= inc_nxt;
      playing_note_r <= playing_note_nxt;
      note_active_r  <= note_active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    if (in_accept) begin
      s1_cmd_r    <= in_tuser[0];
      s1_status_r <= in_tdata[7:0];
      s1_note_r   <= in_tdata[14:8];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;

endmodule

@@ tb/midi_note_sine_oscillator_core_tb.sv @@
// Regression bench for midi_note_sine_oscillator_core: directed and random ticks and MIDI
// messages, with every sample checked against a bench-side oscillator predictor.
// Depends on nsosc_pkg and the oscillator RTL.
module midi_note_sine_oscillator_core_tb;

  localparam int NOTE_SPAN  = 64;
  localparam int RATE_HZ    = 44100;
  localparam int WAVE_SIZE  = 1024;
  localparam int QUARTER    = WAVE_SIZE / 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = nsosc_pkg::CMD_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  logic [7:0]  sine_wave [WAVE_SIZE];
  logic [31:0] pitch_step [NOTE_SPAN];
  logic [31:0] one_hz_step;

  logic [31:0] osc_phase;
  logic [31:0] osc_step;
  logic [6:0]  held_note;
  logic        note_held;

  logic [7:0]  expected_samples [$];
  logic [7:0]  wanted_sample;
  int          err_count = 0;
  logic        in_gaps_on = 1'b1;
  logic        out_stalls_on = 1'b1;

  midi_note_sine_oscillator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Truncated 127 * sin(pi/2 * m / QUARTER) from a Q30 Taylor series.
  function automatic longint unsigned sine_127(longint unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    if (m >= QUARTER) begin
      return 127;
    end
    x = (nsosc_pkg::HALF_PI_Q30 * m) / QUARTER;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int i = 1; i <= 6; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return ($unsigned(acc) * 127) >> 30;
  endfunction

  initial begin
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned acc;
    longint unsigned num;
    longint unsigned den;
    longint unsigned ratio_pow [12];
    logic            fits;
    longint unsigned v;
    int              quad;
    int              m;
    int              d;
    int              o;
    int              s;
    int              sh;
    for (int k = 0; k < WAVE_SIZE; k++) begin
      quad = k / QUARTER;
      m = k % QUARTER;
      v = (quad % 2 == 1) ? sine_127(QUARTER - m) : sine_127(m);
      sine_wave[k] = (quad < 2) ? 8'(128 + v) : 8'(128 - v);
    end
    lo = nsosc_pkg::Q30_ONE;
    hi = nsosc_pkg::Q30_ONE * 2;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      acc = nsosc_pkg::Q30_ONE;
      fits = 1'b1;
      for (int k = 0; k < 12; k++) begin
        if (fits) begin
          acc = (acc * mid) >> 30;
          if (acc > nsosc_pkg::Q30_ONE * 2) begin
            fits = 1'b0;
          end
        end
      end
      if (fits) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    ratio_pow[0] = nsosc_pkg::Q30_ONE;
    for (int k = 1; k < 12; k++) begin
      ratio_pow[k] = (ratio_pow[k - 1] * lo) >> 30;
    end
    for (int i = 0; i < NOTE_SPAN; i++) begin
      d = int'(nsosc_pkg::FIRST_NOTE) + i - 69;
      o = (d >= 0) ? d / 12 : -((-d + 11) / 12);
      s = d - 12 * o;
      sh = o + 2;
      num = 440 * ratio_pow[s];
      den = RATE_HZ;
      if (sh >= 0) begin
        num = num << sh;
      end else begin
        den = den << -sh;
      end
      pitch_step[i] = 32'((num + den / 2) / den);
    end
    one_hz_step = 32'(((64'd1 << 32) + RATE_HZ / 2) / RATE_HZ);
    osc_phase = '0;
    osc_step = one_hz_step;
    held_note = '0;
    note_held = 1'b0;
  end

  function automatic void advance_oscillator(logic cmd, logic [7:0] status, logic [6:0] note);
    int slot;
    slot = int'(note) - int'(nsosc_pkg::FIRST_NOTE);
    if (cmd == nsosc_pkg::CMD_TICK) begin
      expected_samples.push_back(sine_wave[osc_phase[31:22]]);
      osc_phase = osc_phase + osc_step;
    end else if (slot >= 0 && slot < NOTE_SPAN) begin
      if (status == nsosc_pkg::NOTE_ON) begin
        osc_step = pitch_step[slot];
        held_note = note;
        note_held = 1'b1;
      end else if (status == nsosc_pkg::NOTE_OFF && note_held && held_note == note) begin
        osc_step = one_hz_step;
        note_held = 1'b0;
      end
    end
  endfunction

  task automatic send_event(input logic cmd, input logic [7:0] status, input logic [6:0] note);
    while (in_gaps_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, note, status};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    advance_oscillator(cmd, status, note);
  endtask

  task automatic test_reset_state();
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_TICK, 8'hFF, 7'd127);
  endtask

  task automatic test_out_of_range_notes();
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON, nsosc_pkg::FIRST_NOTE - 7'd1);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON,
               nsosc_pkg::FIRST_NOTE + 7'(NOTE_SPAN));
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON, 7'd127);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON, 7'd0);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF, 7'd0);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
  endtask

  task automatic test_note_changes();
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON, nsosc_pkg::FIRST_NOTE);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON,
               nsosc_pkg::FIRST_NOTE + 7'(NOTE_SPAN - 1));
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF, nsosc_pkg::FIRST_NOTE);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF,
               nsosc_pkg::FIRST_NOTE + 7'(NOTE_SPAN - 1));
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF,
               nsosc_pkg::FIRST_NOTE + 7'(NOTE_SPAN - 1));
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
  endtask

  task automatic test_other_status();
    send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON, 7'd60);
    send_event(nsosc_pkg::CMD_MIDI, 8'h91, 7'd40);
    send_event(nsosc_pkg::CMD_MIDI, 8'h81, 7'd60);
    send_event(nsosc_pkg::CMD_MIDI, 8'h00, 7'd50);
    send_event(nsosc_pkg::CMD_MIDI, 8'hFF, 7'd99);
    send_event(nsosc_pkg::CMD_TICK, 8'h00, 7'd0);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_event(nsosc_pkg::CMD_TICK, 8'($urandom), 7'($urandom));
      end else if (pick < 78) begin
        send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_ON,
                   nsosc_pkg::FIRST_NOTE + 7'($urandom_range(NOTE_SPAN - 1)));
      end else if (pick < 88) begin
        if ($urandom_range(9) < 7) begin
          send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF, held_note);
        end else begin
          send_event(nsosc_pkg::CMD_MIDI, nsosc_pkg::NOTE_OFF,
                     nsosc_pkg::FIRST_NOTE + 7'($urandom_range(NOTE_SPAN - 1)));
        end
      end else if (pick < 94) begin
        send_event(nsosc_pkg::CMD_MIDI, 8'($urandom), 7'($urandom));
      end else begin
        send_event(nsosc_pkg::CMD_MIDI,
                   ($urandom_range(1) == 1) ? nsosc_pkg::NOTE_ON : nsosc_pkg::NOTE_OFF,
                   ($urandom_range(1) == 1) ?
                     7'($urandom_range(int'(nsosc_pkg::FIRST_NOTE) - 1)) :
                     7'($urandom_range(127, 100)));
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    test_random_traffic(count);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got %0d", $time, out_tdata);
        err_count++;
      end else begin
        wanted_sample = expected_samples.pop_front();
        if (out_tdata !== wanted_sample) begin
          $display("%0t: sample mismatch, expected %0d, got %0d", $time, wanted_sample,
                   out_tdata);
          err_count++;
        end
      end
    end
    out_tready <= !(out_stalls_on && $urandom_range(99) < 25);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_out_of_range_notes();
    test_note_changes();
    test_other_status();
    test_random_traffic(430);
    test_back_to_back(200);
    test_random_traffic(220);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (expected_samples.size() != 0) begin
      err_count++;
    end
    if (err_count == 0) begin
      $display("midi_note_sine_oscillator_core regression: pass");
    end else begin
      $display("midi_note_sine_oscillator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("midi_note_sine_oscillator_core regression: fail");
    $finish;
  end

endmodule
